// ===== rtl/core/frame_checksum_history_compare_top_defines.svh =====
// Assertion macros shared by the checksum history block.
`ifndef FRAME_CHECKSUM_HISTORY_COMPARE_TOP_DEFINES_SVH
`define FRAME_CHECKSUM_HISTORY_COMPARE_TOP_DEFINES_SVH

`define FCHC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fchc: implication check failed");

`define FCHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fchc: next-cycle check failed");

`endif

// ===== rtl/core/fchc_pkg.sv =====
package fchc_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam logic [7:0] MIN_SETTLE_LAG = 8'd6;
  localparam logic [7:0] SETTLE_EXTRA = 8'd2;

  localparam logic       REQ_STORE   = 1'b0;
  localparam logic       REQ_COMPARE = 1'b1;

  localparam logic [2:0] OC_STORED      = 3'd0;
  localparam logic [2:0] OC_DROPPED     = 3'd1;
  localparam logic [2:0] OC_NOT_LOCAL   = 3'd2;
  localparam logic [2:0] OC_NOT_REMOTE  = 3'd3;
  localparam logic [2:0] OC_NO_HISTORY  = 3'd4;
  localparam logic [2:0] OC_MATCH       = 3'd5;
  localparam logic [2:0] OC_MISMATCH    = 3'd6;

  localparam logic CFG_ROLLBACK_BUDGET = 1'b0;
  localparam logic CFG_ACTIVE_DELAY    = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] frame_id;
    logic        [31:0] checksum_value;
    logic signed [31:0] current_frame;
    logic signed [31:0] confirmed_frame;
    logic signed [31:0] remote_confirmed;
  } in_t;

  typedef struct packed {
    logic        [2:0]  outcome;
    logic        [31:0] local_checksum;
    logic               desync_seen;
    logic signed [31:0] first_desync_frame;
  } out_t;

  typedef enum logic [2:0] {
    STEP_CLEAR   = 3'd0,
    STEP_IDLE    = 3'd1,
    STEP_CHECK   = 3'd2,
    STEP_EXAM    = 3'd3,
    STEP_ADVANCE = 3'd4,
    STEP_READ    = 3'd5,
    STEP_EMIT    = 3'd6
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS     = 3'd0,
    C_IDX_LAST   = 3'd1,
    C_IN_VALID   = 3'd2,
    C_EARLY      = 3'd3,
    C_HIT        = 3'd4,
    C_PROBE_LAST = 3'd5,
    C_OUT_BUSY   = 3'd6
  } cond_t;

  typedef struct packed {
    logic  clr_wr;
    logic  accept;
    logic  mem_rd;
    logic  check;
    logic  exam;
    logic  idx_inc;
    logic  probe_inc;
    logic  emit;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ctl_t;

  typedef struct packed {
    logic idx_last;
    logic in_valid;
    logic early;
    logic hit;
    logic probe_last;
    logic out_busy;
  } flags_t;

  function automatic ctl_t ucode(input step_t pc);
    ctl_t w;
    w = '{clr_wr: 1'b0, accept: 1'b0, mem_rd: 1'b0, check: 1'b0, exam: 1'b0,
          idx_inc: 1'b0, probe_inc: 1'b0, emit: 1'b0, cond: C_ALWAYS,
          tgt_t: STEP_IDLE, tgt_f: STEP_IDLE};
    unique case (pc)
      STEP_CLEAR: begin
        w.clr_wr = 1'b1; w.idx_inc = 1'b1;
        w.cond = C_IDX_LAST; w.tgt_t = STEP_IDLE; w.tgt_f = STEP_CLEAR;
      end
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.cond = C_IN_VALID; w.tgt_t = STEP_CHECK; w.tgt_f = STEP_IDLE;
      end
      STEP_CHECK: begin
        w.mem_rd = 1'b1; w.check = 1'b1;
        w.cond = C_EARLY; w.tgt_t = STEP_EMIT; w.tgt_f = STEP_EXAM;
      end
      STEP_EXAM: begin
        w.exam = 1'b1;
        w.cond = C_HIT; w.tgt_t = STEP_EMIT; w.tgt_f = STEP_ADVANCE;
      end
      STEP_ADVANCE: begin
        w.idx_inc = 1'b1; w.probe_inc = 1'b1;
        w.cond = C_PROBE_LAST; w.tgt_t = STEP_EMIT; w.tgt_f = STEP_READ;
      end
      STEP_READ: begin
        w.mem_rd = 1'b1;
        w.cond = C_ALWAYS; w.tgt_t = STEP_EXAM; w.tgt_f = STEP_EXAM;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = C_OUT_BUSY; w.tgt_t = STEP_EMIT; w.tgt_f = STEP_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.tgt_t = STEP_IDLE; w.tgt_f = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/fchc_seq.sv =====
module fchc_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  fchc_pkg::flags_t flags,
  output fchc_pkg::ctl_t  ctl
);

  fchc_pkg::step_t pc_r;
  fchc_pkg::step_t pc_nxt;
  logic            take;

  assign ctl = fchc_pkg::ucode(pc_r);

  always_comb begin
    unique case (ctl.cond)
      fchc_pkg::C_ALWAYS:     take = 1'b1;
      fchc_pkg::C_IDX_LAST:   take = flags.idx_last;
      fchc_pkg::C_IN_VALID:   take = flags.in_valid;
      fchc_pkg::C_EARLY:      take = flags.early;
      fchc_pkg::C_HIT:        take = flags.hit;
      fchc_pkg::C_PROBE_LAST: take = flags.probe_last;
      fchc_pkg::C_OUT_BUSY:   take = flags.out_busy;
      default:                take = 1'b1;
    endcase
    pc_nxt = take ? ctl.tgt_t : ctl.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= fchc_pkg::STEP_CLEAR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/core/frame_checksum_history_compare_top.sv =====
// Per-frame checksum history with remote digest comparison. After reset the
// table is swept clean slot by slot, during which in_stall stays high
// (configuration writes are still taken). A word that is decided without a
// table lookup (dropped store, unsettled compare, negative compare frame)
// goes from acceptance through the check step to the result register; a word
// resolved at its home slot also passes an exam step, and every further probe
// adds an advance, a read and an exam step, as each probe is a read of the
// single-port table followed by its examination. The next word is taken in
// the cycle after the result is registered. A new word is accepted while a
// result still waits on out_stall. TABLE_DEPTH must be a power of two.
`include "frame_checksum_history_compare_top_defines.svh"

module frame_checksum_history_compare_top #(
  parameter int TABLE_DEPTH = fchc_pkg::TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fchc_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output fchc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_idx,
  input  logic [5:0]    cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);

  fchc_pkg::ctl_t   ctl;
  fchc_pkg::flags_t flags;

  logic [63:0] mem [TABLE_DEPTH];
  logic [63:0] rd_r;
  logic        mem_we;
  logic [63:0] mem_wdata;

  logic [5:0]  budget_r;
  logic [5:0]  delay_r;
  logic [7:0]  lag_r;
  logic [7:0]  lag_sum;

  fchc_pkg::in_t item_r, item_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] probe_r, probe_nxt;
  logic [2:0]    outcome_r, outcome_nxt;
  logic [31:0]   found_r, found_nxt;
  logic          drift_seen_r, drift_seen_nxt;
  logic [31:0]   drift_frame_r, drift_frame_nxt;
  logic          out_valid_r, out_valid_nxt;
  fchc_pkg::out_t out_data_r, out_data_nxt;

  logic signed [33:0] local_settled;
  logic signed [33:0] frame_wide;
  logic               not_local;
  logic               not_remote;
  logic               early;
  logic [2:0]         early_code;
  logic               is_store;
  logic               slot_empty;
  logic               slot_eq;
  logic               hit;
  logic               out_busy;

  fchc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  assign lag_sum  = {2'b00, budget_r} + {2'b00, delay_r} + fchc_pkg::SETTLE_EXTRA;
  assign in_stall = !ctl.accept;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_busy  = out_valid_r && out_stall;
  assign is_store  = (item_r.req_type == fchc_pkg::REQ_STORE);

  always_comb begin
    frame_wide    = {{2{item_r.frame_id[31]}}, item_r.frame_id};
    local_settled = $signed({{2{item_r.current_frame[31]}}, item_r.current_frame})
                    - $signed({26'd0, lag_r});
    not_local  = (item_r.frame_id > item_r.confirmed_frame) || (frame_wide > local_settled);
    not_remote = !item_r.remote_confirmed[31]
                 && (item_r.frame_id > item_r.remote_confirmed);
    if (is_store) begin
      early      = item_r.frame_id[31];
      early_code = fchc_pkg::OC_DROPPED;
    end else begin
      early = not_local || not_remote || item_r.frame_id[31];
      priority if (not_local) begin
        early_code = fchc_pkg::OC_NOT_LOCAL;
      end else if (not_remote) begin
        early_code = fchc_pkg::OC_NOT_REMOTE;
      end else begin
        early_code = fchc_pkg::OC_NO_HISTORY;
      end
    end
  end

  assign slot_empty = rd_r[63];
  assign slot_eq    = (rd_r[63:32] == item_r.frame_id);
  assign hit        = slot_empty || slot_eq;

  assign flags.idx_last   = (idx_r == AW'(TABLE_DEPTH - 1));
  assign flags.in_valid   = in_valid;
  assign flags.early      = early;
  assign flags.hit        = hit;
  assign flags.probe_last = (probe_r == AW'(TABLE_DEPTH - 1));
  assign flags.out_busy   = out_busy;

  assign mem_we    = ctl.clr_wr || (ctl.exam && is_store && hit);
  assign mem_wdata = ctl.clr_wr ? {32'hFFFF_FFFF, 32'd0}
                                : {item_r.frame_id, item_r.checksum_value};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= mem_wdata;
    end
    if (ctl.mem_rd) begin
      rd_r <= mem[idx_r];
    end
  end

  always_comb begin
    item_nxt        = item_r;
    idx_nxt         = idx_r;
    probe_nxt       = probe_r;
    outcome_nxt     = outcome_r;
    found_nxt       = found_r;
    drift_seen_nxt  = drift_seen_r;
    drift_frame_nxt = drift_frame_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;

    if (ctl.accept && in_valid) begin
      item_nxt  = in_data;
      idx_nxt   = in_data.frame_id[AW-1:0];
      probe_nxt = '0;
    end
    if (ctl.idx_inc) begin
      idx_nxt = flags.idx_last ? '0 : idx_r + AW'(1);
    end
    if (ctl.probe_inc) begin
      probe_nxt = probe_r + AW'(1);
    end
    if (ctl.check) begin
      found_nxt   = '0;
      outcome_nxt = early ? early_code
                          : (is_store ? fchc_pkg::OC_DROPPED : fchc_pkg::OC_NO_HISTORY);
    end
    if (ctl.exam && hit) begin
      if (is_store) begin
        outcome_nxt = fchc_pkg::OC_STORED;
      end else if (slot_eq) begin
        found_nxt = rd_r[31:0];
        if (rd_r[31:0] == item_r.checksum_value) begin
          outcome_nxt = fchc_pkg::OC_MATCH;
        end else begin
          outcome_nxt = fchc_pkg::OC_MISMATCH;
          if (!drift_seen_r) begin
            drift_seen_nxt  = 1'b1;
            drift_frame_nxt = item_r.frame_id;
          end
        end
      end
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.emit && !out_busy) begin
      out_valid_nxt                   = 1'b1;
      out_data_nxt.outcome            = outcome_r;
      out_data_nxt.local_checksum     = found_r;
      out_data_nxt.desync_seen        = drift_seen_r;
      out_data_nxt.first_desync_frame = drift_frame_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r      <= '0;
      delay_r       <= '0;
      lag_r         <= fchc_pkg::MIN_SETTLE_LAG;
      idx_r         <= '0;
      drift_seen_r  <= 1'b0;
      drift_frame_r <= 32'hFFFF_FFFF;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          fchc_pkg::CFG_ROLLBACK_BUDGET: budget_r <= cfg_wdata;
          fchc_pkg::CFG_ACTIVE_DELAY:    delay_r  <= cfg_wdata;
          default:                       budget_r <= budget_r;
        endcase
      end
      lag_r         <= (lag_sum < fchc_pkg::MIN_SETTLE_LAG) ? fchc_pkg::MIN_SETTLE_LAG : lag_sum;
      idx_r         <= idx_nxt;
      drift_seen_r  <= drift_seen_nxt;
      drift_frame_r <= drift_frame_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    probe_r    <= probe_nxt;
    outcome_r  <= outcome_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  `FCHC_ASSERT_NEXT(a_accept_then_check, clk, rst_n, in_valid && !in_stall, ctl.check)
  `FCHC_ASSERT_IMPLY(a_clear_blocks_input, clk, rst_n, ctl.clr_wr, in_stall)
  `FCHC_ASSERT_IMPLY(a_table_write_store, clk, rst_n, mem_we && !ctl.clr_wr,
                     is_store && !item_r.frame_id[31])
  `FCHC_ASSERT_NEXT(a_desync_sticky, clk, rst_n, drift_seen_r,
                    drift_seen_r && $stable(drift_frame_r))

endmodule

// ===== test/frame_checksum_history_compare_top_tb.sv =====
`timescale 1ns / 100ps

module frame_checksum_history_compare_top_tb;

  localparam int DEPTH = fchc_pkg::TABLE_DEPTH_DEF;
  localparam int STALL_LIMIT = 100000;
  localparam int PHASE_WORDS = 225;
  localparam int MAXF = 32'h7FFF_FFFF;

  typedef struct {
    fchc_pkg::in_t  word;
    bit             fixed;
    fchc_pkg::out_t want;
  } dir_row_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  fchc_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall = 1'b0;
  fchc_pkg::out_t out_data;
  logic           cfg_we;
  logic           cfg_idx;
  logic [5:0]     cfg_wdata;

  int          hist_frame [DEPTH];
  logic [31:0] hist_sum [DEPTH];
  logic        drift_seen;
  int          drift_at;
  logic [5:0]  budget_reg;
  logic [5:0]  delay_reg;

  fchc_pkg::out_t verdict_q [$];
  dir_row_t       dir_rows [$];
  int             fail_count = 0;
  int             quiet_cycles = 0;
  bit             steady = 1'b0;
  int             game_frame;

  frame_checksum_history_compare_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int locate_frame(int f);
    int idx;
    int p;
    if (f < 0) return -1;
    idx = f % DEPTH;
    for (p = 0; p < DEPTH; p++) begin
      if (hist_frame[idx] == f) return idx;
      if (hist_frame[idx] < 0) return -1;
      idx = (idx + 1) % DEPTH;
    end
    return -1;
  endfunction

  function automatic logic [2:0] store_checksum(int f, logic [31:0] sum);
    int idx;
    int p;
    if (f < 0) return fchc_pkg::OC_DROPPED;
    idx = f % DEPTH;
    for (p = 0; p < DEPTH; p++) begin
      if (hist_frame[idx] < 0 || hist_frame[idx] == f) begin
        hist_frame[idx] = f;
        hist_sum[idx] = sum;
        return fchc_pkg::OC_STORED;
      end
      idx = (idx + 1) % DEPTH;
    end
    return fchc_pkg::OC_DROPPED;
  endfunction

  function automatic fchc_pkg::out_t judge_word(fchc_pkg::in_t w);
    fchc_pkg::out_t r;
    longint lag;
    longint local_ok;
    longint remote_ok;
    longint fr;
    longint cur;
    longint conf;
    longint rem;
    int     slot;
    fr = $signed(w.frame_id);
    cur = $signed(w.current_frame);
    conf = $signed(w.confirmed_frame);
    rem = $signed(w.remote_confirmed);
    r.local_checksum = '0;
    if (w.req_type == fchc_pkg::REQ_STORE) begin
      r.outcome = store_checksum(int'(fr), w.checksum_value);
    end else begin
      lag = longint'(budget_reg) + longint'(delay_reg) + longint'(fchc_pkg::SETTLE_EXTRA);
      if (lag < longint'(fchc_pkg::MIN_SETTLE_LAG)) lag = longint'(fchc_pkg::MIN_SETTLE_LAG);
      local_ok = cur - lag;
      remote_ok = local_ok;
      if (rem >= 0 && rem < remote_ok) remote_ok = rem;
      if (fr > conf || fr > local_ok) begin
        r.outcome = fchc_pkg::OC_NOT_LOCAL;
      end else if (fr > remote_ok) begin
        r.outcome = fchc_pkg::OC_NOT_REMOTE;
      end else begin
        slot = locate_frame(int'(fr));
        if (slot < 0) begin
          r.outcome = fchc_pkg::OC_NO_HISTORY;
        end else begin
          r.local_checksum = hist_sum[slot];
          if (hist_sum[slot] == w.checksum_value) begin
            r.outcome = fchc_pkg::OC_MATCH;
          end else begin
            r.outcome = fchc_pkg::OC_MISMATCH;
            if (!drift_seen) begin
              drift_seen = 1'b1;
              drift_at = int'(fr);
            end
          end
        end
      end
    end
    r.desync_seen = drift_seen;
    r.first_desync_frame = drift_at;
    return r;
  endfunction

  function automatic dir_row_t row(bit fixed, logic rq, int fr, logic [31:0] sum, int cur,
                                   int conf, int rem, logic [2:0] oc, logic [31:0] lsum,
                                   logic ds, int df);
    dir_row_t r;
    r.word = '{rq, fr, sum, cur, conf, rem};
    r.fixed = fixed;
    r.want = '{oc, lsum, ds, df};
    return r;
  endfunction

  function automatic int noise_signed();
    return ($urandom_range(0, 7) == 0) ? -1 : int'($urandom & 32'h7FFF_FFFF);
  endfunction

  function automatic fchc_pkg::in_t make_word();
    fchc_pkg::in_t w;
    int            pick;
    int            slot;
    pick = $urandom_range(0, 99);
    w.checksum_value = $urandom;
    w.current_frame = game_frame + $urandom_range(0, 8);
    w.confirmed_frame = ($urandom_range(0, 9) == 0) ? -1 : game_frame - $urandom_range(0, 20);
    w.remote_confirmed = ($urandom_range(0, 3) == 0) ? -1 : game_frame - $urandom_range(0, 150);
    if (pick < 45) begin
      w.req_type = fchc_pkg::REQ_STORE;
      if ($urandom_range(0, 9) == 0) begin
        w.frame_id = (game_frame >= 3 * DEPTH) ?
                     game_frame - DEPTH * $urandom_range(1, 3) : game_frame + DEPTH;
      end else begin
        w.frame_id = game_frame;
        if ($urandom_range(0, 4) != 0) game_frame++;
      end
    end else if (pick < 92) begin
      w.req_type = fchc_pkg::REQ_COMPARE;
      w.frame_id = game_frame - $urandom_range(0, 140);
      slot = locate_frame(w.frame_id);
      if (slot >= 0 && $urandom_range(0, 3) != 0) w.checksum_value = hist_sum[slot];
    end else begin
      w.req_type = 1'($urandom_range(0, 1));
      w.frame_id = noise_signed();
      w.current_frame = noise_signed();
      w.confirmed_frame = noise_signed();
      w.remote_confirmed = noise_signed();
    end
    return w;
  endfunction

  task automatic send_word(fchc_pkg::in_t w, bit fixed, fchc_pkg::out_t want);
    fchc_pkg::out_t predicted;
    predicted = judge_word(w);
    verdict_q.push_back(fixed ? want : predicted);
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_lag(logic [5:0] budget, logic [5:0] delay);
    cfg_we <= 1'b1;
    cfg_idx <= fchc_pkg::CFG_ROLLBACK_BUDGET;
    cfg_wdata <= budget;
    @(posedge clk);
    cfg_idx <= fchc_pkg::CFG_ACTIVE_DELAY;
    cfg_wdata <= delay;
    @(posedge clk);
    cfg_we <= 1'b0;
    budget_reg = budget;
    delay_reg = delay;
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%h, got 0x%h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 36);
  end

  always @(posedge clk) begin
    fchc_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("result word with no expectation waiting");
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        check_field("outcome", 32'(want.outcome), 32'(out_data.outcome));
        check_field("local_checksum", want.local_checksum, out_data.local_checksum);
        check_field("desync_seen", 32'(want.desync_seen), 32'(out_data.desync_seen));
        check_field("first_desync_frame", want.first_desync_frame,
                    out_data.first_desync_frame);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int         i;
    int         ph;
    int         k;
    logic [5:0] budgets [6];
    logic [5:0] delays [6];
    int         starts [6];

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = fchc_pkg::CFG_ROLLBACK_BUDGET;
    cfg_wdata = '0;
    for (i = 0; i < DEPTH; i++) begin
      hist_frame[i] = -1;
      hist_sum[i] = '0;
    end
    drift_seen = 1'b0;
    drift_at = -1;
    budget_reg = '0;
    delay_reg = '0;

    budgets = '{6'd63, 6'd0, 6'd1, 6'd0, 6'd17, 6'd0};
    delays = '{6'd63, 6'd0, 6'd2, 6'd4, 6'd40, 6'd0};
    starts = '{200, 2147480000, 60000, 1000000, 5000, 0};
    budgets[5] = $urandom_range(0, 63);
    delays[5] = $urandom_range(0, 63);
    starts[5] = DEPTH * $urandom_range(1, 400000) + 1500;

    dir_rows.push_back(row(1, fchc_pkg::REQ_COMPARE, 0, 0, 0, 0, -1,
                           fchc_pkg::OC_NOT_LOCAL, 0, 0, -1));
    dir_rows.push_back(row(1, fchc_pkg::REQ_STORE, -1, '1, -1, -1, -1,
                           fchc_pkg::OC_DROPPED, 0, 0, -1));
    dir_rows.push_back(row(1, fchc_pkg::REQ_STORE, MAXF, '1, MAXF, MAXF, MAXF,
                           fchc_pkg::OC_STORED, 0, 0, -1));
    dir_rows.push_back(row(1, fchc_pkg::REQ_STORE, 0, 0, 0, 0, 0,
                           fchc_pkg::OC_STORED, 0, 0, -1));
    dir_rows.push_back(row(1, fchc_pkg::REQ_COMPARE, 0, 0, 6, 0, -1,
                           fchc_pkg::OC_MATCH, 0, 0, -1));
    dir_rows.push_back(row(1, fchc_pkg::REQ_COMPARE, 0, 0, 6, -1, -1,
                           fchc_pkg::OC_NOT_LOCAL, 0, 0, -1));
    dir_rows.push_back(row(1, fchc_pkg::REQ_COMPARE, 0, 0, 5, 0, -1,
                           fchc_pkg::OC_NOT_LOCAL, 0, 0, -1));
    dir_rows.push_back(row(1, fchc_pkg::REQ_COMPARE, 5, 0, 100, 100, 4,
                           fchc_pkg::OC_NOT_REMOTE, 0, 0, -1));
    dir_rows.push_back(row(1, fchc_pkg::REQ_COMPARE, 4, 0, 100, 100, 4,
                           fchc_pkg::OC_NO_HISTORY, 0, 0, -1));
    dir_rows.push_back(row(1, fchc_pkg::REQ_COMPARE, -1, 0, 100, 100, -1,
                           fchc_pkg::OC_NO_HISTORY, 0, 0, -1));
    dir_rows.push_back(row(1, fchc_pkg::REQ_COMPARE, MAXF, '1, MAXF, MAXF, MAXF,
                           fchc_pkg::OC_NOT_LOCAL, 0, 0, -1));
    dir_rows.push_back(row(1, fchc_pkg::REQ_COMPARE, -1, 0, -1, -1, -1,
                           fchc_pkg::OC_NOT_LOCAL, 0, 0, -1));
    dir_rows.push_back(row(0, fchc_pkg::REQ_STORE, 4095, 32'h1234_5678, 0, 0, 0,
                           fchc_pkg::OC_STORED, 0, 0, 0));
    dir_rows.push_back(row(0, fchc_pkg::REQ_STORE, 8191, 32'h0A5A_5A5A, 0, 0, 0,
                           fchc_pkg::OC_STORED, 0, 0, 0));
    dir_rows.push_back(row(0, fchc_pkg::REQ_COMPARE, 8191, 32'h0A5A_5A5A, 9000, 9000, -1,
                           fchc_pkg::OC_STORED, 0, 0, 0));
    dir_rows.push_back(row(0, fchc_pkg::REQ_COMPARE, 4095, 0, 9000, 9000, 8999,
                           fchc_pkg::OC_STORED, 0, 0, 0));
    dir_rows.push_back(row(0, fchc_pkg::REQ_COMPARE, 0, 1, 9000, 9000, -1,
                           fchc_pkg::OC_STORED, 0, 0, 0));
    dir_rows.push_back(row(0, fchc_pkg::REQ_STORE, 0, 32'hDEAD_BEEF, 0, 0, 0,
                           fchc_pkg::OC_STORED, 0, 0, 0));
    dir_rows.push_back(row(0, fchc_pkg::REQ_COMPARE, 0, 32'hDEAD_BEEF, 9000, 9000, 0,
                           fchc_pkg::OC_STORED, 0, 0, 0));
    dir_rows.push_back(row(0, fchc_pkg::REQ_COMPARE, 12287, 0, 20000, 20000, -1,
                           fchc_pkg::OC_STORED, 0, 0, 0));
    dir_rows.push_back(row(0, fchc_pkg::REQ_STORE, MAXF, 0, 0, 0, 0,
                           fchc_pkg::OC_STORED, 0, 0, 0));
    dir_rows.push_back(row(0, fchc_pkg::REQ_COMPARE, 8191, 0, 9000, 9000, MAXF,
                           fchc_pkg::OC_STORED, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[j]) send_word(dir_rows[j].word, dir_rows[j].fixed, dir_rows[j].want);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      set_lag(budgets[ph], delays[ph]);
      game_frame = starts[ph];
      steady = (ph == 3);
      for (k = 0; k < PHASE_WORDS; k++) send_word(make_word(), 1'b0, '0);
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
